@@ rtl/dq_pkg.sv @@
// Package for the double-ended queue: field widths, command and status codes,
// and the per-cell control type. Used by the interfaces, the cell and the top level.
package dq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int CMD_W     = 3;
	localparam int STATUS_W  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_LIST       = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Operation broadcast to every cell in the same cycle
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHR,
		CELL_SHL,
		CELL_ROT,
		CELL_PUT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     sel;
	} cell_ctrl_t;

endpackage

@@ rtl/dq_cmd_if.sv @@
// Command channel of the double-ended queue: valid/ready handshake and request payload.
// Depends on dq_pkg.
interface dq_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [dq_pkg::CMD_W-1:0]    cmd;
	logic signed [dq_pkg::DATA_W-1:0] push_value;

	modport source (output valid, output cmd, output push_value, input ready);
	modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

@@ rtl/dq_res_if.sv @@
// Result channel of the double-ended queue: valid/ready handshake and result payload.
// Depends on dq_pkg.
interface dq_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [dq_pkg::DATA_W-1:0]  elem_value;
	logic [dq_pkg::STATUS_W-1:0]       status;
	logic                              last;

	modport source (output valid, output elem_value, output status, output last, input ready);
	modport sink   (input valid, input elem_value, input status, input last, output ready);
endinterface

@@ rtl/dq_cell.sv @@
// One storage cell of the queue chain; holds a single element and trades it with
// its neighbours. Depends on dq_pkg.
module dq_cell (
	input  logic                              clk,
	input  dq_pkg::cell_ctrl_t                ctrl,
	input  logic signed [dq_pkg::DATA_W-1:0]  left_val,
	input  logic signed [dq_pkg::DATA_W-1:0]  right_val,
	input  logic signed [dq_pkg::DATA_W-1:0]  head_val,
	input  logic signed [dq_pkg::DATA_W-1:0]  push_val,
	output logic signed [dq_pkg::DATA_W-1:0]  val
);
	import dq_pkg::*;

	logic signed [DATA_W-1:0] val_q;

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_SHR: val_q <= left_val;
			CELL_SHL: val_q <= right_val;
			// wrap the head round to the tail position
			CELL_ROT: val_q <= ctrl.sel ? head_val : right_val;
			CELL_PUT: if (ctrl.sel) begin
				val_q <= push_val;
			end
			default: val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

@@ rtl/double_ended_queue.sv @@
// Channel   | Dir | Payload                        | Handshake
// request   | in  | cmd, push_value                | valid/ready
// result    | out | elem_value, status, last       | valid/ready
//
// Push and pop requests give one result each. A listing is accepted and then
// streams each held element in turn from the head of the cell chain as the chain
// rotates, pausing while the result is stalled; request ready stays low meanwhile.
// Reset clears the element count and control state; cell contents are not reset.
// A stalled result register holds its item and blocks further requests.
// Top level of the double-ended queue. Depends on dq_pkg, dq_cmd_if, dq_res_if, dq_cell.
module double_ended_queue #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	dq_cmd_if.sink         request,
	dq_res_if.source       result
);
	import dq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic {S_IDLE, S_LIST} state_t;

	state_t                   state_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            remain_q;
	logic                     res_valid_q;
	logic signed [DATA_W-1:0] res_value_q;
	status_t                  res_status_q;
	logic                     res_last_q;

	logic                     in_fire;
	logic                     slot_free;
	logic                     full;
	logic                     empty;
	cell_op_t                 op;
	logic signed [DATA_W-1:0] cell_val [DEPTH];
	cell_ctrl_t               ctrl [DEPTH];

	assign slot_free     = !res_valid_q || result.ready;
	assign request.ready = (state_q == S_IDLE) && slot_free;
	assign in_fire       = request.valid && request.ready;
	assign full          = (count_q == CW'(DEPTH));
	assign empty         = (count_q == '0);

	always_comb begin
		op = CELL_HOLD;
		if (in_fire) begin
			case (request.cmd)
				CMD_PUSH_FRONT: if (!full) op = CELL_SHR;
				CMD_PUSH_BACK:  if (!full) op = CELL_PUT;
				CMD_POP_FRONT:  if (!empty) op = CELL_SHL;
				default:        op = CELL_HOLD;
			endcase
		end else if (state_q == S_LIST && slot_free) begin
			op = CELL_ROT;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_v;
		logic signed [DATA_W-1:0] right_v;

		assign ctrl[i].op  = op;
		assign ctrl[i].sel = (op == CELL_PUT && count_q == CW'(i))
			|| (op == CELL_ROT && count_q == CW'(i + 1));

		if (i == 0) begin : g_first
			assign left_v = request.push_value;
		end else begin : g_mid
			assign left_v = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign right_v = cell_val[i];
		end else begin : g_inner
			assign right_v = cell_val[i+1];
		end

		dq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl[i]),
			.left_val  (left_v),
			.right_val (right_v),
			.head_val  (cell_val[0]),
			.push_val  (request.push_value),
			.val       (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			remain_q     <= '0;
			res_valid_q  <= 1'b0;
			res_value_q  <= '0;
			res_status_q <= ST_OK;
			res_last_q   <= 1'b0;
		end else begin
			if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (in_fire) begin
					res_value_q <= '0;
					res_last_q  <= 1'b1;
					unique case (request.cmd)
						CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
							res_valid_q  <= 1'b1;
							res_status_q <= full ? ST_FULL : ST_OK;
							if (!full) begin
								count_q <= count_q + 1'b1;
							end
						end
						CMD_POP_FRONT, CMD_POP_BACK: begin
							res_valid_q  <= 1'b1;
							res_status_q <= empty ? ST_EMPTY : ST_OK;
							if (!empty) begin
								count_q <= count_q - 1'b1;
							end
						end
						CMD_LIST: begin
							if (empty) begin
								res_valid_q  <= 1'b1;
								res_status_q <= ST_EMPTY;
							end else begin
								remain_q <= count_q;
								state_q  <= S_LIST;
							end
						end
						default: ; // drop unknown commands
					endcase
				end
				S_LIST: if (slot_free) begin
					res_valid_q  <= 1'b1;
					res_value_q  <= cell_val[0];
					res_status_q <= ST_OK;
					res_last_q   <= (remain_q == CW'(1));
					remain_q     <= remain_q - 1'b1;
					if (remain_q == CW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid      = res_valid_q;
	assign result.elem_value = res_value_q;
	assign result.status     = res_status_q;
	assign result.last       = res_last_q;

endmodule

@@ tb/dq_checker.sv @@
`timescale 1ns / 1ps
// Checker for the double-ended queue: watches the request and result channels,
// keeps its own copy of the queue contents and compares every result in order.
// Depends on dq_pkg, dq_cmd_if and dq_res_if.
module dq_checker #(
	parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	dq_cmd_if     request,
	dq_res_if     result,
	output int    mismatches,
	output int    pending
);
	import dq_pkg::*;

	typedef struct {
		logic signed [DATA_W-1:0] elem_value;
		status_t                  status;
		logic                     last;
	} deque_result_t;

	logic signed [DATA_W-1:0] cells [DEPTH];
	int unsigned              head;
	int unsigned              held;
	deque_result_t            due_results [$];

	task automatic flag_error(input string msg);
		$display("%0t ns: dq_checker: %s", $time, msg);
		mismatches++;
	endtask

	task automatic queue_due(input deque_result_t r);
		due_results = {due_results, r};
	endtask

	task automatic predict_deque_op(input logic [CMD_W-1:0] code,
			input logic signed [DATA_W-1:0] value);
		deque_result_t r;
		r.elem_value = '0;
		r.status     = ST_OK;
		r.last       = 1'b1;
		case (code)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (held == DEPTH) begin
					r.status = ST_FULL;
				end else if (code == CMD_PUSH_FRONT) begin
					head = (head + DEPTH - 1) % DEPTH;
					cells[head] = value;
					held++;
				end else begin
					cells[(head + held) % DEPTH] = value;
					held++;
				end
				queue_due(r);
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (code == CMD_POP_FRONT)
						head = (head + 1) % DEPTH;
					held--;
				end
				queue_due(r);
			end
			CMD_LIST: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
					queue_due(r);
				end else begin
					for (int unsigned i = 0; i < held; i++) begin
						r.elem_value = cells[(head + i) % DEPTH];
						r.last       = (i + 1 == held);
						queue_due(r);
					end
				end
			end
			default: ; // unused codes: drop silently
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		if (!arst_n) begin
			head       = 0;
			held       = 0;
			mismatches = 0;
			due_results.delete();
		end else begin
			// Predict before checking so a result always finds its request queued
			if (request.valid && request.ready)
				predict_deque_op(request.cmd, request.push_value);
			if (result.valid && result.ready) begin
				if (due_results.size() == 0) begin
					flag_error($sformatf("unexpected result: value %0d status %0d last %0b",
						result.elem_value, result.status, result.last));
				end else begin
					want = due_results[0];
					due_results.delete(0);
					if (result.elem_value !== want.elem_value || result.status !== want.status
							|| result.last !== want.last)
						flag_error($sformatf({"result mismatch: value %0d status %0d last %0b,",
							" expected %0d %0d %0b"}, result.elem_value, result.status,
							result.last, want.elem_value, want.status, want.last));
				end
			end
		end
		pending = due_results.size();
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the double-ended queue testbench: clock, reset, request stimulus and
// result back-pressure; the verdict comes from dq_checker's mismatch count.
// Depends on dq_pkg, dq_cmd_if, dq_res_if, double_ended_queue and dq_checker.
module testbench;
	import dq_pkg::*;

	localparam int RANDOM_ITEMS  = 405;
	localparam int PHASE_ITEMS   = 50;
	localparam int BIAS_ITEMS    = 25;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 300000;

	localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

	typedef enum {PACE_STEADY, PACE_SLOW_SOURCE, PACE_SLOW_SINK, PACE_BOTH} pace_t;

	logic  clk = 1'b0;
	logic  arst_n;
	int    mismatches;
	int    pending;
	int    cycle_count = 0;
	pace_t pace;

	dq_cmd_if req_ch ();
	dq_res_if res_ch ();

	double_ended_queue u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (req_ch),
		.result  (res_ch)
	);

	dq_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.request    (req_ch),
		.result     (res_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Back-pressure on the result channel
	always @(posedge clk) begin
		case (pace)
			PACE_SLOW_SINK: res_ch.ready <= ($urandom_range(99) >= 75);
			PACE_BOTH:      res_ch.ready <= ($urandom_range(99) >= 16);
			default:        res_ch.ready <= 1'b1;
		endcase
	end

	function automatic logic signed [DATA_W-1:0] random_value();
		case ($urandom_range(7))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// Pick a command; push_pct steers the queue towards full or empty
	function automatic logic [CMD_W-1:0] random_command(input int unsigned push_pct);
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return CMD_LIST;
		if (roll < 10)
			return CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
		if ($urandom_range(99) < push_pct)
			return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
		return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
	endfunction

	task automatic send_request(input logic [CMD_W-1:0] code,
			input logic signed [DATA_W-1:0] value);
		int unsigned idle_pct;
		logic        granted;
		idle_pct = (pace == PACE_SLOW_SOURCE) ? 75 : (pace == PACE_BOTH) ? 16 : 0;
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= code;
		req_ch.push_value <= value;
		// Sample ready mid-cycle, once it has settled for the coming edge
		do begin
			@(negedge clk);
			granted = req_ch.ready;
			@(posedge clk);
		end while (!granted);
	endtask

	task automatic wait_for_drain();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		logic [CMD_W-1:0] code;
		int unsigned      push_pct;
		int               counted;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.cmd        = CMD_PUSH_FRONT;
		req_ch.push_value = '0;
		res_ch.ready      = 1'b0;
		pace              = PACE_STEADY;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Empty queue: removals and listing report empty, unused code is dropped
		send_request(CMD_POP_FRONT, random_value());
		send_request(CMD_POP_BACK, random_value());
		send_request(CMD_LIST, random_value());
		send_request(CMD_UNUSED_LAST, random_value());
		send_request(CMD_PUSH_BACK, 32'sh7FFF_FFFF);
		send_request(CMD_PUSH_FRONT, 32'sh8000_0000);
		send_request(CMD_PUSH_BACK, '0);
		send_request(CMD_PUSH_FRONT, -32'sd1);
		send_request(CMD_LIST, '0);
		// Fill to capacity, then push onto the full queue from both ends
		for (int i = 0; i < 12; i++)
			send_request(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, random_value());
		send_request(CMD_PUSH_FRONT, random_value());
		send_request(CMD_PUSH_BACK, random_value());
		send_request(CMD_LIST, '0);
		send_request(CMD_POP_FRONT, '0);
		send_request(CMD_POP_BACK, '0);

		counted  = 0;
		push_pct = 50;
		while (counted < RANDOM_ITEMS) begin
			if (counted % PHASE_ITEMS == 0) begin
				wait_for_drain();
				pace = pace_t'((counted / PHASE_ITEMS) % 4);
			end
			if (counted % BIAS_ITEMS == 0) begin
				case ($urandom_range(2))
					0:       push_pct = 80;
					1:       push_pct = 20;
					default: push_pct = 50;
				endcase
			end
			code = random_command(push_pct);
			send_request(code, random_value());
			if (code <= CMD_LIST)
				counted++;
		end

		wait_for_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
